### src/riot_pkg.sv
// riot_pkg: shared types, codes and prescaler tables for the RAM / I/O / timer block.
// No dependencies; imported by every module of the block except riot_ram.
`timescale 1ns / 1ps

package riot_pkg;

   // Default RAM depth
   localparam int RAM_WORDS_DEF = 128;

   // Operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Address bits of the bus decode
   localparam int ADDR_REG_BIT   = 9;
   localparam int ADDR_WSEL_BIT  = 2;
   localparam int ADDR_TIMER_BIT = 4;

   // Register read codes (addr[2:0])
   localparam logic [2:0] REG_PORT_A     = 3'd0;
   localparam logic [2:0] REG_DIR_A      = 3'd1;
   localparam logic [2:0] REG_PORT_B     = 3'd2;
   localparam logic [2:0] REG_DIR_B      = 3'd3;
   localparam logic [2:0] REG_TIMER      = 3'd4;
   localparam logic [2:0] REG_STATUS     = 3'd5;
   localparam logic [2:0] REG_TIMER_ALT  = 3'd6;
   localparam logic [2:0] REG_STATUS_ALT = 3'd7;

   // Port write codes (addr[1:0])
   localparam logic [1:0] WR_PORT_A = 2'd0;
   localparam logic [1:0] WR_DIR_A  = 2'd1;
   localparam logic [1:0] WR_PORT_B = 2'd2;
   localparam logic [1:0] WR_DIR_B  = 2'd3;

   // Interrupt status bit positions
   localparam int STATUS_TIMER_BIT = 7;
   localparam int STATUS_PA7_BIT   = 6;

   // Reset interval: divide by 1024
   localparam logic [1:0] INTERVAL_RESET = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  addr;
      logic [7:0]  write_data;
      logic [31:0] elapsed_cycles;
      logic [7:0]  pins_a;
      logic [7:0]  pins_b;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_flag;
      logic       edge_flag;
   } rsp_type;

   typedef struct packed {
      logic [7:0] count;
      logic [9:0] prescale;
      logic       underflow;
      logic       wrapped;
   } timer_state_type;

   // Prescaler shift per interval select
   function automatic logic [3:0] step_shift(input logic [1:0] sel);
      logic [3:0] sh;
      case (sel)
         2'd0:    sh = 4'd0;
         2'd1:    sh = 4'd3;
         2'd2:    sh = 4'd6;
         default: sh = 4'd10;
      endcase
      return sh;
   endfunction

   // Prescaler mask (step size minus one) per interval select
   function automatic logic [9:0] step_mask(input logic [1:0] sel);
      logic [9:0] m;
      case (sel)
         2'd0:    m = 10'd0;
         2'd1:    m = 10'd7;
         2'd2:    m = 10'd63;
         default: m = 10'd1023;
      endcase
      return m;
   endfunction

endpackage

### src/riot_ram.sv
// riot_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module riot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/riot_timer.sv
// riot_timer: combinational advance of the interval timer and prescaler by an elapsed count.
// Depends on riot_pkg.
`timescale 1ns / 1ps

module riot_timer
   import riot_pkg::*;
(
   input  logic [31:0]     elapsed,
   input  logic [1:0]      interval,
   input  timer_state_type cur,
   output timer_state_type nxt
);

   logic [3:0]  sh;
   logic [32:0] sum;
   logic [32:0] ticks;
   logic [18:0] base;
   logic        over;
   logic [7:0]  left_low;

   assign sh    = step_shift(interval);
   assign sum   = {1'b0, elapsed} + 33'(cur.prescale);
   assign ticks = sum >> sh;
   // Cycles up to and including the underflow, counted from the prescaler phase
   assign base  = (19'(cur.count) + 19'd1) << sh;
   assign over  = (ticks[32:8] != '0) || (ticks[7:0] > cur.count);
   // Only the low byte of the cycles left after underflow matters
   assign left_low = sum[7:0] - base[7:0];

   // Advance the timer; hold everything when no cycles went by
   always_comb begin
      nxt = cur;
      if (elapsed != '0) begin
         nxt.prescale = sum[9:0] & step_mask(interval);
         nxt.wrapped  = 1'b0;
         if (!cur.underflow) begin
            if (over) begin
               nxt.count     = 8'hFF - left_low;
               nxt.underflow = 1'b1;
               nxt.wrapped   = (left_low == 8'h00);
            end else begin
               nxt.count = cur.count - ticks[7:0];
            end
         end else begin
            nxt.count   = cur.count - elapsed[7:0];
            nxt.wrapped = ((cur.count - elapsed[7:0]) == 8'hFF);
         end
      end
   end

endmodule

### src/riot_core.sv
// riot_core: timer, edge detector, port and status registers, and the bus access decode.
// Depends on riot_pkg and riot_timer.
`timescale 1ns / 1ps

module riot_core
   import riot_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  req_type    item,
   input  logic [7:0] ram_data,
   output rsp_type    result
);

   timer_state_type tmr_ff, tmr_in, tmr_adv;
   logic [1:0] interval_ff, interval_in;
   logic       pa7_ff, pa7_in;
   logic       edge_rising_ff, edge_rising_in;
   logic       sync_ff, sync_in;
   logic       last_ff, last_in;
   logic [7:0] port_a_out_ff, port_a_out_in;
   logic [7:0] port_a_dir_ff, port_a_dir_in;
   logic [7:0] port_b_out_ff, port_b_out_in;
   logic [7:0] port_b_dir_ff, port_b_dir_in;
   logic       pa7_raw;
   logic [7:0] rd;

   riot_timer u_timer (
      .elapsed  (item.elapsed_cycles),
      .interval (interval_ff),
      .cur      (tmr_ff),
      .nxt      (tmr_adv)
   );

   // PA7 source: driven level when an output, pin level otherwise
   assign pa7_raw = port_a_dir_ff[7] ? port_a_out_ff[7] : item.pins_a[7];

   // Sample the edge detector, then perform the access
   always_comb begin
      tmr_in         = tmr_adv;
      interval_in    = interval_ff;
      pa7_in         = pa7_ff;
      edge_rising_in = edge_rising_ff;
      sync_in        = sync_ff;
      last_in        = last_ff;
      port_a_out_in  = port_a_out_ff;
      port_a_dir_in  = port_a_dir_ff;
      port_b_out_in  = port_b_out_ff;
      port_b_dir_in  = port_b_dir_ff;
      rd             = '0;

      if (item.elapsed_cycles != '0) begin
         sync_in = pa7_raw;
         last_in = sync_ff;
         if ((last_ff != sync_ff) && (sync_ff == edge_rising_ff)) begin
            pa7_in = 1'b1;
         end
      end

      case (item.op)
         OP_READ: begin
            if (!item.addr[ADDR_REG_BIT]) begin
               rd = ram_data;
            end else begin
               unique case (item.addr[2:0]) inside
                  REG_PORT_A: rd = (port_a_out_ff | ~port_a_dir_ff) & item.pins_a;
                  REG_DIR_A:  rd = port_a_dir_ff;
                  REG_PORT_B: rd = (port_b_out_ff | ~port_b_dir_ff)
                                   & (item.pins_b | port_b_dir_ff);
                  REG_DIR_B:  rd = port_b_dir_ff;
                  REG_TIMER, REG_TIMER_ALT: begin
                     // keep the flag when it was set in this very cycle
                     if (!tmr_adv.wrapped) begin
                        tmr_in.underflow = 1'b0;
                     end
                     rd = tmr_adv.count;
                  end
                  REG_STATUS, REG_STATUS_ALT: begin
                     rd[STATUS_TIMER_BIT] = tmr_adv.underflow;
                     rd[STATUS_PA7_BIT]   = pa7_in;
                     pa7_in               = 1'b0;
                  end
                  default: rd = '0;
               endcase
            end
         end
         OP_WRITE: begin
            if (item.addr[ADDR_REG_BIT]) begin
               if (item.addr[ADDR_WSEL_BIT]) begin
                  if (item.addr[ADDR_TIMER_BIT]) begin
                     interval_in     = item.addr[1:0];
                     tmr_in.count    = item.write_data;
                     tmr_in.prescale = step_mask(item.addr[1:0]);
                     if (!tmr_adv.wrapped) begin
                        tmr_in.underflow = 1'b0;
                     end
                  end else begin
                     edge_rising_in = item.addr[0];
                  end
               end else begin
                  unique case (item.addr[1:0])
                     WR_PORT_A: port_a_out_in = item.write_data;
                     WR_DIR_A:  port_a_dir_in = item.write_data;
                     WR_PORT_B: port_b_out_in = item.write_data;
                     WR_DIR_B:  port_b_dir_in = item.write_data;
                     default:   port_b_dir_in = item.write_data;
                  endcase
               end
            end
         end
         default: ;
      endcase

      result.read_data  = rd;
      result.timer_flag = tmr_in.underflow;
      result.edge_flag  = pa7_in;
   end

   // Commit state when the request leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         tmr_ff         <= '0;
         interval_ff    <= INTERVAL_RESET;
         pa7_ff         <= 1'b0;
         edge_rising_ff <= 1'b0;
         sync_ff        <= 1'b0;
         last_ff        <= 1'b0;
         port_a_out_ff  <= '0;
         port_a_dir_ff  <= '0;
         port_b_out_ff  <= '0;
         port_b_dir_ff  <= '0;
      end else if (advance) begin
         tmr_ff         <= tmr_in;
         interval_ff    <= interval_in;
         pa7_ff         <= pa7_in;
         edge_rising_ff <= edge_rising_in;
         sync_ff        <= sync_in;
         last_ff        <= last_in;
         port_a_out_ff  <= port_a_out_in;
         port_a_dir_ff  <= port_a_dir_in;
         port_b_out_ff  <= port_b_out_in;
         port_b_dir_ff  <= port_b_dir_in;
      end
   end

endmodule

### src/riot_timer_io_ram.sv
// Requests pass from the input register through the core to the response register.
// Throughput: one request per cycle; the input register stalls only while a
// response waits in the output register and the output side stalls.
// Reset is synchronous: it clears timer, flags, ports and the RAM valid bits at
// once, so every RAM byte reads zero until written; no clearing pass is needed.
// Top level: input register, RAM with per-entry valid bits, core, response register.
// Depends on riot_pkg, riot_ram and riot_core.
`timescale 1ns / 1ps

module riot_timer_io_ram
   import riot_pkg::*;
#(
   parameter int RAM_WORDS = RAM_WORDS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int RAM_AW = $clog2(RAM_WORDS);

   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic                 load_rsp;
   logic                 s1_move;
   logic                 accept;
   logic [RAM_WORDS-1:0] ram_valid_ff;
   logic                 rd_valid_ff;
   logic [RAM_AW-1:0]    ram_idx;
   logic                 ram_wr;
   logic [7:0]           ram_q;
   logic [7:0]           ram_data;
   rsp_type              core_rsp;

   // Handshake control
   assign load_rsp  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && load_rsp;
   assign req_stall = s1_valid_ff && !load_rsp;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // RAM access happens in request order at accept time
   assign ram_idx = req_data.addr[RAM_AW-1:0];
   assign ram_wr  = accept && (req_data.op == OP_WRITE) && !req_data.addr[ADDR_REG_BIT];

   riot_ram #(
      .WIDTH (8),
      .DEPTH (RAM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_idx),
      .wr_data (req_data.write_data),
      .rd_en   (accept),
      .rd_addr (ram_idx),
      .rd_data (ram_q)
   );

   // Unwritten entries read as zero
   assign ram_data = rd_valid_ff ? ram_q : 8'h00;

   riot_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_move),
      .item     (s1_req_ff),
      .ram_data (ram_data),
      .result   (core_rsp)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ram_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (load_rsp) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (ram_wr) begin
            ram_valid_ff[ram_idx] <= 1'b1;
         end
         if (accept) begin
            rd_valid_ff <= ram_valid_ff[ram_idx];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/riot_checker.sv
// riot_checker: port-level assertions for riot_timer_io_ram, attached by bind.
// Depends on riot_pkg.
`timescale 1ns / 1ps

module riot_checker
   import riot_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Drop the response after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Stall requests only behind a waiting, stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   // Deliver a response for a request accepted while no response is waiting
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

endmodule

bind riot_timer_io_ram riot_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### dv/tb_riot_timer_io_ram.sv
// tb_riot_timer_io_ram: self-checking bench for the RAM / I/O / timer block.
// Sends bus requests with random idle cycles and backpressure and checks each response
// against a shadow copy of the device state. Depends on riot_pkg and riot_timer_io_ram.
`timescale 1ns / 1ps

module tb_riot_timer_io_ram;
   import riot_pkg::*;

   localparam int          RAM_WORDS      = RAM_WORDS_DEF;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          DRAIN_CYCLES   = 4;
   localparam logic [1:0]  OP_UNDEF       = 2'd3;
   localparam logic [9:0]  BUS_REG_BASE   = 10'h200;
   localparam logic [9:0]  TIMER_WRITE    = 10'h014;
   localparam logic [9:0]  EDGE_WRITE     = 10'h004;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   riot_timer_io_ram u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // shadow device state
   logic [7:0] shadow_ram [RAM_WORDS];
   logic [7:0] shadow_timer;
   logic [9:0] shadow_prescale;
   logic [1:0] shadow_interval;
   logic       shadow_underflow, shadow_pa7, shadow_wrapped, shadow_rising;
   logic       shadow_sync, shadow_last;
   logic [7:0] shadow_a_out, shadow_a_dir, shadow_b_out, shadow_b_dir;

   rsp_type     pending_responses [$];
   int unsigned requests_sent = 0;
   int unsigned error_count   = 0;
   bit          idle_enable   = 1'b1;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int          quiet_cycles  = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t ns: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic int unsigned interval_shift(input logic [1:0] sel);
      case (sel)
         2'd0:    return 0;
         2'd1:    return 3;
         2'd2:    return 6;
         default: return 10;
      endcase
   endfunction

   function automatic void reset_shadow();
      foreach (shadow_ram[i]) shadow_ram[i] = 8'h00;
      shadow_timer     = 8'h00;
      shadow_prescale  = 10'd0;
      shadow_interval  = INTERVAL_RESET;
      shadow_underflow = 1'b0;
      shadow_pa7       = 1'b0;
      shadow_wrapped   = 1'b0;
      shadow_rising    = 1'b0;
      shadow_sync      = 1'b0;
      shadow_last      = 1'b0;
      shadow_a_out     = 8'h00;
      shadow_a_dir     = 8'h00;
      shadow_b_out     = 8'h00;
      shadow_b_dir     = 8'h00;
   endfunction

   // Advance the timer and PA7 detector, then perform the access; return the response
   function automatic rsp_type predict_bus_response(input req_type item);
      rsp_type         result;
      longint unsigned left, total, ticks, reach;
      logic [9:0]      old_prescale;
      int unsigned     shift;
      logic            pa7_raw, pa7_stable;
      result       = '0;
      shift        = interval_shift(shadow_interval);
      old_prescale = shadow_prescale;
      left         = item.elapsed_cycles;

      // hold all timing state when no cycles have elapsed
      if (left != 0) begin
         shadow_wrapped  = 1'b0;
         total           = left + old_prescale;
         shadow_prescale = 10'(total & ((64'd1 << shift) - 64'd1));
         if (!shadow_underflow) begin
            ticks = total >> shift;
            if (ticks > shadow_timer) begin
               reach            = shadow_timer;
               reach            = (reach + 64'd1) << shift;
               left             = left - (reach - old_prescale);
               shadow_wrapped   = (left == 0);
               shadow_timer     = 8'hFF;
               shadow_underflow = 1'b1;
            end else begin
               shadow_timer = shadow_timer - ticks[7:0];
               left         = 0;
            end
         end
         // after underflow the timer counts every cycle
         if (shadow_underflow) begin
            shadow_timer   = shadow_timer - left[7:0];
            shadow_wrapped = (shadow_timer == 8'hFF);
         end
         // two-stage synchronizer on PA7, edge of the selected polarity sets the flag
         pa7_raw     = shadow_a_dir[7] ? shadow_a_out[7] : item.pins_a[7];
         pa7_stable  = shadow_sync;
         shadow_sync = pa7_raw;
         if (shadow_last != pa7_stable && pa7_stable == shadow_rising) shadow_pa7 = 1'b1;
         shadow_last = pa7_stable;
      end

      if (item.op == OP_READ) begin
         if (!item.addr[ADDR_REG_BIT]) begin
            result.read_data = shadow_ram[item.addr[6:0]];
         end else begin
            case (item.addr[2:0])
               REG_PORT_A: result.read_data = (shadow_a_out | ~shadow_a_dir) & item.pins_a;
               REG_DIR_A:  result.read_data = shadow_a_dir;
               REG_PORT_B: result.read_data = (shadow_b_out | ~shadow_b_dir)
                                              & (item.pins_b | shadow_b_dir);
               REG_DIR_B:  result.read_data = shadow_b_dir;
               REG_TIMER, REG_TIMER_ALT: begin
                  if (!shadow_wrapped) shadow_underflow = 1'b0;
                  result.read_data = shadow_timer;
               end
               default: begin
                  result.read_data[STATUS_TIMER_BIT] = shadow_underflow;
                  result.read_data[STATUS_PA7_BIT]   = shadow_pa7;
                  shadow_pa7 = 1'b0;
               end
            endcase
         end
      end else if (item.op == OP_WRITE) begin
         if (!item.addr[ADDR_REG_BIT]) begin
            shadow_ram[item.addr[6:0]] = item.write_data;
         end else if (item.addr[ADDR_WSEL_BIT]) begin
            if (item.addr[ADDR_TIMER_BIT]) begin
               shadow_interval = item.addr[1:0];
               shadow_timer    = item.write_data;
               shadow_prescale = 10'((32'd1 << interval_shift(shadow_interval)) - 32'd1);
               if (!shadow_wrapped) shadow_underflow = 1'b0;
            end else begin
               shadow_rising = item.addr[0];
            end
         end else begin
            case (item.addr[1:0])
               WR_PORT_A: shadow_a_out = item.write_data;
               WR_DIR_A:  shadow_a_dir = item.write_data;
               WR_PORT_B: shadow_b_out = item.write_data;
               default:   shadow_b_dir = item.write_data;
            endcase
         end
      end

      result.timer_flag = shadow_underflow;
      result.edge_flag  = shadow_pa7;
      return result;
   endfunction

   function automatic req_type make_request(input logic [1:0] op, input logic [9:0] addr,
                                            input logic [7:0] data, input logic [31:0] elapsed,
                                            input logic [7:0] pa, input logic [7:0] pb);
      req_type item;
      item.op             = op;
      item.addr           = addr;
      item.write_data     = data;
      item.elapsed_cycles = elapsed;
      item.pins_a         = pa;
      item.pins_b         = pb;
      return item;
   endfunction

   // Mostly short gaps, now and then long and full-width ones
   function automatic logic [31:0] pick_elapsed();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return 32'($urandom_range(3));
      if (roll < 75) return 32'($urandom_range(200));
      if (roll < 95) return 32'($urandom_range(5000));
      return 32'($urandom);
   endfunction

   function automatic req_type noise_request();
      return make_request(2'($urandom_range(3)), 10'($urandom), 8'($urandom),
                          pick_elapsed(), 8'($urandom), 8'($urandom));
   endfunction

   // Offer one request, idling at random first; record its response once accepted
   task automatic send_request(input req_type item);
      while (idle_enable && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_responses.push_back(predict_bus_response(item));
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with no request pending", 32'(rsp_data), 32'd0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.read_data !== want.read_data)
               report_mismatch("read_data", 32'(rsp_data.read_data), 32'(want.read_data));
            if (rsp_data.timer_flag !== want.timer_flag)
               report_mismatch("timer_flag", 32'(rsp_data.timer_flag), 32'(want.timer_flag));
            if (rsp_data.edge_flag !== want.edge_flag)
               report_mismatch("edge_flag", 32'(rsp_data.edge_flag), 32'(want.edge_flag));
         end
      end
   end

   // Drive response backpressure: random stalls plus requested long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(99) < 11);
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0)
                || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("riot_timer_io_ram verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_ram_access();
      send_request(make_request(OP_WRITE, 10'h000, 8'hFF, 32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_WRITE, 10'h07F, 8'hA5, 32'd0, 8'hFF, 8'hFF));
      send_request(make_request(OP_READ, 10'h000, 8'h00, 32'd0, 8'h00, 8'h00));
      // upper address bits alias 0x1FF onto byte 0x07F written above
      send_request(make_request(OP_READ, 10'h1FF, 8'h00, 32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_READ, 10'h005, 8'h00, 32'd0, 8'h00, 8'h00));
   endtask

   task automatic test_port_registers();
      send_request(make_request(OP_WRITE, BUS_REG_BASE | {8'd0, WR_DIR_A}, 8'hF0,
                                32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_WRITE, BUS_REG_BASE | {8'd0, WR_PORT_A}, 8'h5A,
                                32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_PORT_A}, 8'h00,
                                32'd0, 8'hFF, 8'h00));
      send_request(make_request(OP_WRITE, BUS_REG_BASE | {8'd0, WR_DIR_B}, 8'h0F,
                                32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_WRITE, BUS_REG_BASE | {8'd0, WR_PORT_B}, 8'hC3,
                                32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_PORT_B}, 8'h00,
                                32'd0, 8'h00, 8'h00));
   endtask

   task automatic test_timer();
      send_request(make_request(OP_WRITE, BUS_REG_BASE | TIMER_WRITE, 8'h03,
                                32'd0, 8'h00, 8'h00));
      send_request(make_request(OP_TICK, 10'h000, 8'h00, 32'd2, 8'h00, 8'h00));
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_TIMER}, 8'h00,
                                32'd0, 8'h00, 8'h00));
      // underflow lands exactly on this request
      send_request(make_request(OP_TICK, 10'h000, 8'h00, 32'd2, 8'h00, 8'h00));
      // timer read in the underflow cycle keeps the flag
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_TIMER}, 8'h00,
                                32'd0, 8'h00, 8'h00));
      // status read reports the flag without clearing it
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_STATUS_ALT}, 8'h00,
                                32'd1, 8'h00, 8'h00));
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_TIMER_ALT}, 8'h00,
                                32'd0, 8'h00, 8'h00));
      // full-width gaps at the slowest interval
      send_request(make_request(OP_WRITE, BUS_REG_BASE | TIMER_WRITE | 10'd3, 8'hFF,
                                32'hFFFF_FFFF, 8'h00, 8'h00));
      send_request(make_request(OP_TICK, 10'h000, 8'h00, 32'hFFFF_FFFF, 8'h00, 8'h00));
   endtask

   task automatic test_edge_detect();
      send_request(make_request(OP_WRITE, BUS_REG_BASE | EDGE_WRITE | 10'd1, 8'h00,
                                32'd1, 8'h00, 8'h00));
      send_request(make_request(OP_TICK, 10'h000, 8'h00, 32'd1, 8'h80, 8'h00));
      send_request(make_request(OP_TICK, 10'h000, 8'h00, 32'd1, 8'h80, 8'h00));
      send_request(make_request(OP_READ, BUS_REG_BASE | {7'd0, REG_STATUS}, 8'h00,
                                32'd0, 8'h80, 8'h00));
      // undefined operation behaves as a tick
      send_request(make_request(OP_UNDEF, 10'h3FF, 8'hFF, 32'd0, 8'h00, 8'hFF));
   endtask

   // Load the timer, then tick and poll it
   task automatic run_timer_sequence();
      logic [9:0]  addr;
      logic [7:0]  count;
      logic [1:0]  op;
      logic [31:0] gap;
      int unsigned shift, steps;
      addr = 10'($urandom);
      addr[ADDR_REG_BIT]   = 1'b1;
      addr[ADDR_WSEL_BIT]  = 1'b1;
      addr[ADDR_TIMER_BIT] = 1'b1;
      // favor the fast intervals so underflow comes within a few requests
      if ($urandom_range(3) != 0) addr[1] = 1'b0;
      shift = interval_shift(addr[1:0]);
      count = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
      send_request(make_request(OP_WRITE, addr, count, pick_elapsed(),
                                8'($urandom), 8'($urandom)));
      steps = $urandom_range(2, 8);
      repeat (steps) begin
         addr = 10'($urandom);
         op   = OP_READ;
         case ($urandom_range(3))
            0: op = OP_TICK;
            1: addr = {1'b1, 6'($urandom), $urandom_range(1) ? REG_TIMER : REG_TIMER_ALT};
            2: addr = {1'b1, 6'($urandom), $urandom_range(1) ? REG_STATUS : REG_STATUS_ALT};
            default: op = 2'($urandom_range(3));
         endcase
         gap = ($urandom_range(7) == 0) ? pick_elapsed() : 32'($urandom_range(2 << shift));
         send_request(make_request(op, addr, 8'($urandom), gap, 8'($urandom), 8'($urandom)));
      end
   endtask

   // Pick a polarity, wiggle PA7, then read the status
   task automatic run_edge_sequence();
      logic [9:0]  addr;
      logic [7:0]  pins;
      logic [1:0]  op;
      int unsigned steps;
      addr = 10'($urandom);
      addr[ADDR_REG_BIT]   = 1'b1;
      addr[ADDR_WSEL_BIT]  = 1'b1;
      addr[ADDR_TIMER_BIT] = 1'b0;
      send_request(make_request(OP_WRITE, addr, 8'($urandom), 32'($urandom_range(2)),
                                8'($urandom), 8'($urandom)));
      // now and then drive PA7 from the output latch
      if ($urandom_range(3) == 0) begin
         send_request(make_request(OP_WRITE, {1'b1, 6'($urandom), 1'b0, WR_DIR_A},
                                   8'($urandom), 32'd1, 8'($urandom), 8'($urandom)));
         send_request(make_request(OP_WRITE, {1'b1, 6'($urandom), 1'b0, WR_PORT_A},
                                   8'($urandom), 32'd1, 8'($urandom), 8'($urandom)));
      end
      steps = $urandom_range(3, 8);
      pins  = 8'($urandom);
      repeat (steps) begin
         if ($urandom_range(2) != 0) pins[7] = ~pins[7];
         op = ($urandom_range(9) == 0) ? OP_UNDEF : OP_TICK;
         send_request(make_request(op, 10'($urandom), 8'($urandom), 32'($urandom_range(3)),
                                   pins, 8'($urandom)));
      end
      send_request(make_request(OP_READ,
                                {1'b1, 6'($urandom), $urandom_range(1) ? REG_STATUS
                                                                     : REG_STATUS_ALT},
                                8'($urandom), 32'($urandom_range(3)), pins, 8'($urandom)));
   endtask

   // Write a RAM byte, disturb, read it back through an alias
   task automatic run_ram_sequence();
      logic [9:0] addr;
      addr = 10'($urandom);
      addr[ADDR_REG_BIT] = 1'b0;
      send_request(make_request(OP_WRITE, addr, 8'($urandom), pick_elapsed(),
                                8'($urandom), 8'($urandom)));
      repeat ($urandom_range(2)) send_request(noise_request());
      addr[8:7] = 2'($urandom);
      send_request(make_request(OP_READ, addr, 8'($urandom), pick_elapsed(),
                                8'($urandom), 8'($urandom)));
   endtask

   task automatic test_random_traffic(input int unsigned target);
      int unsigned roll;
      while (requests_sent < target) begin
         // keep one long stretch free of idle cycles on both sides
         idle_enable = !(requests_sent >= 500 && requests_sent < 700);
         roll = $urandom_range(99);
         if (roll < 35) run_timer_sequence();
         else if (roll < 55) run_edge_sequence();
         else if (roll < 75) run_ram_sequence();
         else send_request(noise_request());
      end
      idle_enable = 1'b1;
   endtask

   // Stall responses for a long stretch while requests keep coming
   task automatic test_receiver_hold();
      hold_requests++;
      repeat (30) send_request(noise_request());
      wait_drained();
   endtask

   task automatic test_sender_pause();
      wait_drained();
   endtask

   initial begin
      reset_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_ram_access();
      test_port_registers();
      test_timer();
      test_edge_detect();
      test_receiver_hold();
      test_random_traffic(650);
      test_sender_pause();
      test_random_traffic(1255);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("riot_timer_io_ram verification clean");
      end else begin
         $display("riot_timer_io_ram verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
src/riot_pkg.sv
src/riot_ram.sv
src/riot_timer.sv
src/riot_core.sv
src/riot_timer_io_ram.sv
src/riot_checker.sv
dv/tb_riot_timer_io_ram.sv
